// ===== hw/rtl/tpts_pkg.sv =====
// Package for the timed priority task scheduler.
// Holds request codes, status codes, FSM states and the cell structs.
// No dependencies.
package tpts_pkg;

  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned EndlessCodeDef = 65535;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned IdxW = 6;  // covers the deepest table (64)

  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic [1:0] {
    KIND_SUBMIT = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  // Candidate carried down the cell chain during a scan.
  typedef struct packed {
    logic        valid;
    logic [7:0]  prio;
    logic [31:0] seq;
    idx_t        idx;
    logic        fin;   // this run will be the final one
  } cand_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic wr_en;       // store a submitted task
    logic cancel_en;   // cancel request names this slot
    logic tick_start;  // latch the due flag
    logic run_en;      // this cell won the scan
    logic free_all;    // end of tick: drop finished tasks
  } cell_ctl_t;

endpackage

// ===== hw/rtl/tpts_cell.sv =====
// One table slot of the task scheduler plus its stage of the ordering chain.
// Depends on tpts_pkg.
module tpts_cell #(
  parameter int unsigned CellIdx     = 0,
  parameter int unsigned EndlessCode = tpts_pkg::EndlessCodeDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpts_pkg::cell_ctl_t ctl_i,
  input  logic [31:0]        now_i,
  input  logic [7:0]         prio_i,
  input  logic [15:0]        delay_i,
  input  logic [15:0]        iters_i,
  input  logic [31:0]        tag_i,
  input  tpts_pkg::cand_t    cand_i,
  output tpts_pkg::cand_t    cand_o,
  output tpts_pkg::cand_t    cand_d_o,
  output logic               valid_o,
  output logic               ready_o
);
  import tpts_pkg::*;

  logic        valid_q, valid_d;
  logic        ready_q, ready_d;
  logic [7:0]  prio_q;
  logic [31:0] seq_q;
  logic [31:0] due_q;
  logic [15:0] period_q;
  logic [15:0] runs_q;
  logic        endless_q;
  logic        cancelled_q;
  cand_t       cand_q, cand_d, own;
  logic        done;
  logic [16:0] runs_dec;
  logic [32:0] due_sub, due_run;
  logic [31:0] due_sub_sat, due_run_sat;

  assign done = cancelled_q || (!endless_q && (runs_q == 16'd0));
  assign runs_dec = {1'b0, runs_q} - 17'd1;

  assign due_sub = {1'b0, now_i} + {17'd0, delay_i};
  assign due_run = {1'b0, now_i} + {17'd0, period_q};
  assign due_sub_sat = due_sub[32] ? 32'hFFFF_FFFF : due_sub[31:0];
  assign due_run_sat = due_run[32] ? 32'hFFFF_FFFF : due_run[31:0];

  always_comb begin
    own.valid = ready_q;
    own.prio  = prio_q;
    own.seq   = seq_q;
    own.idx   = idx_t'(CellIdx);
    own.fin   = !endless_q && (runs_q == 16'd1);
    // Equal priority goes to the lower tag; a full tie keeps the incoming candidate, from a lower slot.
    if (own.valid && (!cand_i.valid || (own.prio < cand_i.prio) ||
        ((own.prio == cand_i.prio) && (own.seq < cand_i.seq)))) begin
      cand_d = own;
    end else begin
      cand_d = cand_i;
    end
  end

  always_comb begin
    valid_d = valid_q;
    ready_d = ready_q;
    if (ctl_i.wr_en) begin
      valid_d = 1'b1;
    end
    if (ctl_i.tick_start) begin
      ready_d = valid_q && !done && (now_i >= due_q);
    end
    if (ctl_i.run_en) begin
      ready_d = 1'b0;
    end
    if (ctl_i.free_all && valid_q && done) begin
      valid_d = 1'b0;
      ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ready_q <= 1'b0;
      cand_q  <= '0;
    end else begin
      valid_q <= valid_d;
      ready_q <= ready_d;
      cand_q  <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      prio_q      <= prio_i;
      seq_q       <= tag_i;
      due_q       <= due_sub_sat;
      period_q    <= delay_i;
      runs_q      <= iters_i;
      endless_q   <= (iters_i == 16'(EndlessCode));
      cancelled_q <= 1'b0;
    end else if (ctl_i.cancel_en && valid_q && (seq_q == tag_i)) begin
      cancelled_q <= 1'b1;
    end else if (ctl_i.run_en) begin
      if (!endless_q) begin
        runs_q <= runs_dec[15:0];
      end
      if (endless_q || (runs_q != 16'd1)) begin
        due_q <= due_run_sat;
      end
    end
  end

  assign cand_o   = cand_q;
  assign cand_d_o = cand_d;
  assign valid_o  = valid_q;
  assign ready_o  = ready_q;

endmodule

// ===== hw/rtl/timed_priority_task_scheduler.sv =====
// Timed priority task scheduler: a chain of table cells and the request sequencer.
// Submit and cancel answer in the cycle after the request is accepted.
// A tick scans the cell chain once per run result: the winner ripples through the
// registered chain stages to the chain end, then the result register hands it over.
// Requests are taken one at a time; a new request waits until all results are taken.
// Reset (rst_ni low, asynchronous) empties the table and zeroes the tag counter.
// Depends on tpts_pkg and tpts_cell.
module timed_priority_task_scheduler #(
  parameter int unsigned TableDepth  = tpts_pkg::TableDepthDef,
  parameter int unsigned EndlessCode = tpts_pkg::EndlessCodeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  priority_req_i,
  input  logic [15:0] delay_ms_i,
  input  logic [15:0] iterations_i,
  input  logic [3:0]  target_slot_i,
  input  logic [31:0] target_tag_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  reply_kind_o,
  output logic [1:0]  status_o,
  output logic [3:0]  slot_o,
  output logic [31:0] tag_o,
  output logic        finished_o,
  output logic        last_o
);
  import tpts_pkg::*;

  localparam int unsigned CntW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned RunW = $clog2(MaxResults + 1);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [RunW-1:0] nrun_q, nrun_d;
  logic [31:0]     seq_ctr_q;
  logic [31:0]     now_q;

  // result register
  logic        out_valid_q;
  logic [1:0]  reply_kind_q;
  logic [1:0]  status_q;
  logic [3:0]  slot_q;
  logic [31:0] tag_q;
  logic        finished_q;
  logic        last_q;

  logic in_acc, out_acc;
  kind_e kind;

  cell_ctl_t ctl [TableDepth];
  cand_t     chain [TableDepth+1];
  cand_t     cand_d [TableDepth];
  cand_t     winner;
  logic [TableDepth-1:0] valid_v, ready_v;

  logic  full;
  idx_t  free_idx;
  logic  scan_done;
  logic  more_ready;

  // control decoded per cycle
  logic do_submit, do_cancel, do_tick, do_emit, do_free;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_q && out_ready_i;
  assign kind    = kind_e'(kind_i);

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int k = TableDepth - 1; k >= 0; k--) begin
      if (!valid_v[k]) begin
        free_idx = idx_t'(k);
      end
    end
  end
  assign full = &valid_v;

  assign chain[0] = '0;
  assign winner   = cand_d[TableDepth-1];
  assign scan_done = (state_q == ST_SCAN) && (cnt_q == CntW'(TableDepth - 1));

  // Any due task left once the current winner is taken.
  always_comb begin
    more_ready = 1'b0;
    for (int k = 0; k < TableDepth; k++) begin
      if (ready_v[k] && (winner.idx != idx_t'(k))) begin
        more_ready = 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (kind == KIND_TICK)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = winner.valid ? ST_RESP : ST_IDLE;
        end
      end
      ST_RESP: begin
        if (out_acc) begin
          state_d = last_q ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    do_submit  = 1'b0;
    do_cancel  = 1'b0;
    do_tick    = 1'b0;
    do_emit    = 1'b0;
    do_free    = 1'b0;
    cnt_d      = cnt_q;
    nrun_d     = nrun_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_valid_q;
        do_submit  = in_acc && (kind == KIND_SUBMIT);
        do_cancel  = in_acc && (kind == KIND_CANCEL);
        do_tick    = in_acc && (kind == KIND_TICK);
        cnt_d      = '0;
        if (do_tick) begin
          nrun_d = '0;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CntW'(1);
        if (scan_done) begin
          do_emit = winner.valid;
          do_free = !winner.valid;
          if (winner.valid) begin
            nrun_d = nrun_q + RunW'(1);
          end
        end
      end
      ST_RESP: begin
        cnt_d   = '0;
        do_free = out_acc && last_q;
      end
      default: ;
    endcase
  end

  // Per-cell control.
  always_comb begin
    for (int k = 0; k < TableDepth; k++) begin
      ctl[k].wr_en      = do_submit && (iterations_i != 16'd0) && !full &&
                          (free_idx == idx_t'(k));
      ctl[k].cancel_en  = do_cancel && ({2'b00, target_slot_i} == idx_t'(k));
      ctl[k].tick_start = do_tick;
      ctl[k].run_en     = do_emit && (winner.idx == idx_t'(k));
      ctl[k].free_all   = do_free;
    end
  end

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    tpts_cell #(
      .CellIdx    (g),
      .EndlessCode(EndlessCode)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl[g]),
      .now_i   ((state_q == ST_IDLE) ? now_ms_i : now_q),
      .prio_i  (priority_req_i),
      .delay_i (delay_ms_i),
      .iters_i (iterations_i),
      .tag_i   (do_cancel ? target_tag_i : seq_ctr_q),
      .cand_i  (chain[g]),
      .cand_o  (chain[g+1]),
      .cand_d_o(cand_d[g]),
      .valid_o (valid_v[g]),
      .ready_o (ready_v[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      nrun_q      <= '0;
      seq_ctr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      nrun_q  <= nrun_d;
      if (do_submit && (iterations_i != 16'd0) && !full) begin
        seq_ctr_q <= seq_ctr_q + 32'd1;
      end
      if (do_submit || do_cancel || do_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload and latched request time.
  always_ff @(posedge clk_i) begin
    if (do_tick) begin
      now_q <= now_ms_i;
    end
    if (do_submit) begin
      reply_kind_q <= KIND_SUBMIT;
      finished_q   <= 1'b0;
      last_q       <= 1'b1;
      if (iterations_i == 16'd0) begin
        status_q <= STAT_INVALID;
        slot_q   <= '0;
        tag_q    <= '0;
      end else if (full) begin
        status_q <= STAT_FULL;
        slot_q   <= '0;
        tag_q    <= '0;
      end else begin
        status_q <= STAT_OK;
        slot_q   <= free_idx[3:0];
        tag_q    <= seq_ctr_q;
      end
    end else if (do_cancel) begin
      reply_kind_q <= KIND_CANCEL;
      status_q     <= STAT_OK;
      slot_q       <= target_slot_i;
      tag_q        <= target_tag_i;
      finished_q   <= 1'b0;
      last_q       <= 1'b1;
    end else if (do_emit) begin
      reply_kind_q <= KIND_TICK;
      status_q     <= STAT_OK;
      slot_q       <= winner.idx[3:0];
      tag_q        <= winner.seq;
      finished_q   <= winner.fin;
      last_q       <= !more_ready || (nrun_q == RunW'(MaxResults - 1));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign reply_kind_o = reply_kind_q;
  assign status_o     = status_q;
  assign slot_o       = slot_q;
  assign tag_o        = tag_q;
  assign finished_o   = finished_q;
  assign last_o       = last_q;

endmodule

// ===== hw/rtl/tpts_checker.sv =====
// Port-level checks for the task scheduler, bound to the top level.
// Depends on tpts_pkg and timed_priority_task_scheduler.
module tpts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  kind_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  reply_kind_o,
  input logic [1:0]  status_o,
  input logic [3:0]  slot_o,
  input logic [31:0] tag_o,
  input logic        last_o
);
  import tpts_pkg::*;

  // A held result stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tag_o) && $stable(slot_o))
    else $error("result changed while stalled");

  // Submit and cancel answer in the next cycle with a single result.
  a_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KIND_SUBMIT || kind_i == KIND_CANCEL)
    |=> out_valid_o && last_o && (reply_kind_o == $past(kind_i)))
    else $error("missing submit or cancel answer");

  // No new request is taken while a result is pending.
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("request taken with result pending");

  // Failures only come from submit and carry zero slot and tag.
  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK)
    |-> (reply_kind_o == KIND_SUBMIT) && (slot_o == 4'd0) && (tag_o == 32'd0))
    else $error("bad failure result");

endmodule

bind timed_priority_task_scheduler tpts_checker u_tpts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .kind_i      (kind_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .reply_kind_o(reply_kind_o),
  .status_o    (status_o),
  .slot_o      (slot_o),
  .tag_o       (tag_o),
  .last_o      (last_o)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for timed_priority_task_scheduler: directed and random requests checked against
// an in-bench task-table predictor. Depends on tpts_pkg and the scheduler RTL.
module tb;
  import tpts_pkg::*;

  localparam int unsigned Depth = 16;
  localparam logic [15:0] Endless = 16'hFFFF;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainCycles = 400;

  typedef struct {
    kind_e       kind;
    status_e     status;
    logic [3:0]  slot;
    logic [31:0] tag;
    logic        fin;
    logic        last;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = KIND_NONE;
  logic [31:0] now_ms_i = '0;
  logic [7:0]  priority_req_i = '0;
  logic [15:0] delay_ms_i = '0;
  logic [15:0] iterations_i = '0;
  logic [3:0]  target_slot_i = '0;
  logic [31:0] target_tag_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  reply_kind_o;
  logic [1:0]  status_o;
  logic [3:0]  slot_o;
  logic [31:0] tag_o;
  logic        finished_o;
  logic        last_o;

  timed_priority_task_scheduler dut (.*);

  // predictor copy of the task table
  logic        task_valid[Depth];
  logic [7:0]  task_prio[Depth];
  logic [31:0] task_tag[Depth];
  logic [31:0] task_due[Depth];
  logic [15:0] task_period[Depth];
  logic [15:0] task_left[Depth];
  logic        task_endless[Depth];
  logic        task_cancel[Depth];
  logic [31:0] next_tag;

  reply_t      pending_replies[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic [31:0] sim_now = '0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic task_done(int i);
    if (task_cancel[i]) return 1'b1;
    if (task_endless[i]) return 1'b0;
    return task_left[i] == 16'd0;
  endfunction

  function automatic void push_reply(kind_e k, status_e s, logic [3:0] sl, logic [31:0] tg,
                                     logic f, logic l);
    reply_t r;
    r.kind = k; r.status = s; r.slot = sl; r.tag = tg; r.fin = f; r.last = l;
    pending_replies = {pending_replies, r};
  endfunction

  // Works out the replies of one accepted request and updates the table copy.
  function automatic void schedule_model(kind_e k, logic [31:0] now, logic [7:0] prio,
                                         logic [15:0] delay, logic [15:0] iters,
                                         logic [3:0] tslot, logic [31:0] ttag);
    int  free_slot;
    int  best;
    int  runs;
    logic due[Depth];
    logic f;
    free_slot = -1;
    runs = 0;
    case (k)
      KIND_SUBMIT: begin
        if (iters == 16'd0) begin
          push_reply(KIND_SUBMIT, STAT_INVALID, 4'd0, 32'd0, 1'b0, 1'b1);
          return;
        end
        for (int i = 0; i < Depth; i++)
          if (!task_valid[i] && free_slot < 0) free_slot = i;
        if (free_slot < 0) begin
          push_reply(KIND_SUBMIT, STAT_FULL, 4'd0, 32'd0, 1'b0, 1'b1);
          return;
        end
        task_valid[free_slot] = 1'b1;
        task_prio[free_slot] = prio;
        task_tag[free_slot] = next_tag;
        task_due[free_slot] = sat_sum(now, delay);
        task_period[free_slot] = delay;
        task_left[free_slot] = iters;
        task_endless[free_slot] = (iters == Endless);
        task_cancel[free_slot] = 1'b0;
        push_reply(KIND_SUBMIT, STAT_OK, free_slot[3:0], next_tag, 1'b0, 1'b1);
        next_tag = next_tag + 1;
      end
      KIND_CANCEL: begin
        if (task_valid[tslot] && task_tag[tslot] == ttag) task_cancel[tslot] = 1'b1;
        push_reply(KIND_CANCEL, STAT_OK, tslot, ttag, 1'b0, 1'b1);
      end
      KIND_TICK: begin
        for (int i = 0; i < Depth; i++)
          due[i] = task_valid[i] && !task_done(i) && now >= task_due[i];
        while (runs < MaxResults) begin
          best = -1;
          for (int i = 0; i < Depth; i++) begin
            if (!due[i]) continue;
            if (best < 0) best = i;
            else if (task_prio[i] < task_prio[best] ||
                     (task_prio[i] == task_prio[best] && task_tag[i] < task_tag[best]))
              best = i;
          end
          if (best < 0) break;
          due[best] = 1'b0;
          if (!task_endless[best] && task_left[best] != 16'd0)
            task_left[best] = task_left[best] - 16'd1;
          f = task_done(best);
          if (!f) task_due[best] = sat_sum(now, task_period[best]);
          push_reply(KIND_TICK, STAT_OK, best[3:0], task_tag[best], f, 1'b0);
          runs++;
        end
        if (runs > 0) pending_replies[$].last = 1'b1;
        for (int i = 0; i < Depth; i++)
          if (task_valid[i] && task_done(i)) task_valid[i] = 1'b0;
      end
      default: ;  // unknown kind: no reply, no change
    endcase
  endfunction

  // Sends one request; returns at the edge that accepted it, valid left high.
  task automatic send_request(kind_e k, logic [31:0] now, logic [7:0] prio,
                              logic [15:0] delay, logic [15:0] iters,
                              logic [3:0] tslot, logic [31:0] ttag);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    now_ms_i <= now;
    priority_req_i <= prio;
    delay_ms_i <= delay;
    iterations_i <= iters;
    target_slot_i <= tslot;
    target_tag_i <= ttag;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    schedule_model(k, now, prio, delay, iters, tslot, ttag);
  endtask

  // Result checker; also randomizes the receiver's ready.
  always @(posedge clk_i) begin
    reply_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d slot %0d tag %0h", reply_kind_o, slot_o, tag_o);
      end else begin
        e = pending_replies.pop_front();
        if (reply_kind_o !== e.kind || status_o !== e.status || slot_o !== e.slot ||
            tag_o !== e.tag || finished_o !== e.fin || last_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp k%0d s%0d slot%0d tag%0h f%0d l%0d, ",
                      "got k%0d s%0d slot%0d tag%0h f%0d l%0d"},
                     e.kind, e.status, e.slot, e.tag, e.fin, e.last,
                     reply_kind_o, status_o, slot_o, tag_o, finished_o, last_o);
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // zero iterations, plain submit, endless submit, first tick
  task automatic test_submit_checks();
    send_request(KIND_SUBMIT, 32'd0, 8'd7, 16'd5, 16'd0, 4'd0, 32'd0);
    send_request(KIND_SUBMIT, 32'd0, 8'd0, 16'd0, 16'd1, 4'd0, 32'd0);
    send_request(KIND_SUBMIT, 32'd0, 8'hFF, 16'hFFFF, Endless, 4'd0, 32'd0);
    send_request(KIND_TICK, 32'd0, 8'd0, 16'd0, 16'd0, 4'd0, 32'd0);
  endtask

  // fill the table, overflow it, and run a full tick in priority order
  task automatic test_full_table_and_order();
    for (int i = 0; i < 16; i++)
      send_request(KIND_SUBMIT, 32'd10, (i % 3 == 0) ? 8'd4 : 8'($urandom_range(255)),
                   16'd0, 16'd2, 4'd0, 32'd0);
    send_request(KIND_CANCEL, 32'd10, 8'd0, 16'd0, 16'd0, 4'd1, task_tag[1]);
    send_request(KIND_CANCEL, 32'hFFFF_FFFF, 8'd0, 16'd0, 16'd0, 4'hF, 32'hFFFF_FFFF);
    send_request(KIND_NONE, 32'd10, 8'hFF, 16'hFFFF, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
    send_request(KIND_TICK, 32'd70000, 8'd0, 16'd0, 16'd0, 4'd0, 32'd0);
    send_request(KIND_TICK, 32'd70001, 8'd0, 16'd0, 16'd0, 4'd0, 32'd0);
  endtask

  // due time saturates near the top of the time range
  task automatic test_due_saturation();
    send_request(KIND_SUBMIT, 32'hFFFF_FFF0, 8'd1, 16'd100, 16'd1, 4'd0, 32'd0);
    send_request(KIND_TICK, 32'hFFFF_FFFF, 8'd0, 16'd0, 16'd0, 4'd0, 32'd0);
  endtask

  task automatic test_random(int unsigned count, int unsigned idle, int unsigned stall);
    int unsigned pick;
    int unsigned sl;
    logic [15:0] iters;
    logic [15:0] delay;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    sim_now = 32'd100;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 38) begin
        case ($urandom_range(9))
          0: iters = 16'd0;
          1: iters = Endless;
          2: iters = 16'($urandom);
          default: iters = 16'($urandom_range(1, 4));
        endcase
        delay = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
        send_request(KIND_SUBMIT, sim_now, 8'($urandom_range(255)), delay, iters,
                     4'($urandom), $urandom);
      end else if (pick < 55) begin
        sl = $urandom_range(Depth - 1);
        if ($urandom_range(3) != 0 && task_valid[sl])
          send_request(KIND_CANCEL, $urandom, 8'($urandom), 16'($urandom), 16'($urandom),
                       4'(sl), task_tag[sl]);
        else
          send_request(KIND_CANCEL, $urandom, 8'($urandom), 16'($urandom), 16'($urandom),
                       4'(sl), ($urandom_range(1) != 0) ? $urandom : task_tag[sl]);
      end else if (pick < 96) begin
        sim_now = sim_now + $urandom_range(0, 15);
        send_request(KIND_TICK, sim_now, 8'($urandom), 16'($urandom), 16'($urandom),
                     4'($urandom), $urandom);
      end else begin
        send_request(KIND_NONE, $urandom, 8'($urandom), 16'($urandom), 16'($urandom),
                     4'($urandom), $urandom);
      end
    end
    // flush the table so the next phase starts with a clean slate of timings
    for (int i = 0; i < Depth; i++)
      if (task_valid[i])
        send_request(KIND_CANCEL, sim_now, 8'd0, 16'd0, 16'd0, 4'(i), task_tag[i]);
    send_request(KIND_TICK, sim_now, 8'd0, 16'd0, 16'd0, 4'd0, 32'd0);
  endtask

  initial begin
    for (int i = 0; i < Depth; i++) begin
      task_valid[i] = 1'b0; task_prio[i] = '0; task_tag[i] = '0; task_due[i] = '0;
      task_period[i] = '0; task_left[i] = '0; task_endless[i] = 1'b0; task_cancel[i] = 1'b0;
    end
    next_tag = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_submit_checks();
    test_full_table_and_order();
    test_due_saturation();
    test_random(85, 0, 0);
    test_random(85, 59, 0);
    test_random(85, 0, 59);
    test_random(85, 25, 25);

    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== timed_priority_task_scheduler.f =====
hw/rtl/tpts_pkg.sv
hw/rtl/tpts_cell.sv
hw/rtl/timed_priority_task_scheduler.sv
hw/rtl/tpts_checker.sv
bench/tb.sv
